>>> design/tpm_pkg.sv
// Package for the timer pool manager: field widths, request modes, controller states
// and the command, status and response structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package tpm_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ID_W   = 31;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 3'd0,
    MODE_DESTROY = 3'd1,
    MODE_TICK    = 3'd2,
    MODE_QUERY   = 3'd3,
    MODE_PAUSE   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_FIND,
    ST_TICK,
    ST_RESP
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic create_step;
    logic scan;
    logic find;
    logic tick;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic free;
    logic cnt_last;
    logic s1_end;
    logic match;
    logic tick_end;
  } dp_status_t;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   result_id;
    logic [DATA_W-1:0] value_now;
    logic              is_done;
    logic              is_paused;
  } rsp_t;

endpackage

>>> design/tpm_if.sv
// Request and response channel interfaces of the timer pool manager.
// Depends on tpm_pkg for the field widths.
`timescale 1ns / 1ps

interface tpm_req_if import tpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] now_time;
  logic              count_up;
  logic [DATA_W-1:0] start_value;
  logic [DATA_W-1:0] stop_value;
  logic [ID_W-1:0]   target_id;
  logic              pause_flag;

  modport source (
    output valid, mode, now_time, count_up, start_value, stop_value, target_id, pause_flag,
    input  ready
  );
  modport sink (
    input  valid, mode, now_time, count_up, start_value, stop_value, target_id, pause_flag,
    output ready
  );
endinterface

interface tpm_rsp_if import tpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ID_W-1:0]   result_id;
  logic [DATA_W-1:0] value_now;
  logic              is_done;
  logic              is_paused;

  modport source (
    output valid, ok, result_id, value_now, is_done, is_paused,
    input  ready
  );
  modport sink (
    input  valid, ok, result_id, value_now, is_done, is_paused,
    output ready
  );
endinterface

>>> design/tpm_ctrl.sv
// Controller state machine of the timer pool manager: request handshake, scan sequencing
// and the response valid flag. Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_ctrl import tpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] in_mode_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  dp_status_t        st_i,
  output ctl_cmd_t          cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (mode_e'(in_mode_i))
            MODE_CREATE:                          state_d = ST_CREATE;
            MODE_DESTROY, MODE_QUERY, MODE_PAUSE: state_d = ST_FIND;
            MODE_TICK:                            state_d = ST_TICK;
            default:                              state_d = ST_RESP;
          endcase
        end
      end
      ST_CREATE: begin
        cmd_o.create_step = 1'b1;
        if (st_i.free || st_i.cnt_last) begin
          state_d = ST_RESP;
        end
      end
      ST_FIND: begin
        cmd_o.scan = 1'b1;
        cmd_o.find = 1'b1;
        if (st_i.match || st_i.s1_end) begin
          state_d = ST_RESP;
        end
      end
      ST_TICK: begin
        cmd_o.scan = 1'b1;
        cmd_o.tick = 1'b1;
        if (st_i.tick_end) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/tpm_datapath.sv
// Datapath of the timer pool manager: request register, slot flags, slot memories,
// the scan counter, the two-stage tick pipeline and the response registers.
// Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_datapath import tpm_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_cmd_t          cmd_i,
  output dp_status_t        st_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [DATA_W-1:0] now_time_i,
  input  logic              count_up_i,
  input  logic [DATA_W-1:0] start_value_i,
  input  logic [DATA_W-1:0] stop_value_i,
  input  logic [ID_W-1:0]   target_id_i,
  input  logic              pause_flag_i,
  output rsp_t              rsp_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  logic [MODE_W-1:0] mode_q;
  logic [DATA_W-1:0] now_q, start_q, stop_q;
  logic              count_up_q, pause_flag_q;
  logic [ID_W-1:0]   target_id_q;

  logic [NUM_TIMERS-1:0] active_q, finished_q, halted_q;
  logic [ID_W-1:0]       next_id_q;
  logic [IW-1:0]         cnt_q;
  logic                  issue_end_q;

  logic              dir_mem   [NUM_TIMERS];
  logic [DATA_W-1:0] stop_mem  [NUM_TIMERS];
  logic [DATA_W-1:0] value_mem [NUM_TIMERS];
  logic [DATA_W-1:0] stamp_mem [NUM_TIMERS];
  logic [ID_W-1:0]   ident_mem [NUM_TIMERS];

  logic              rd_dir_q;
  logic [DATA_W-1:0] rd_stop_q, rd_value_q, rd_stamp_q;
  logic [ID_W-1:0]   rd_ident_q;

  logic              s1_valid_q;
  logic [IW-1:0]     s1_idx_q;
  logic              s2_valid_q;
  logic [IW-1:0]     s2_idx_q;
  logic [DATA_W-1:0] s2_elapsed_q, s2_value_q, s2_stop_q;
  logic              s2_dir_q, s2_act_q, s2_halted_q;

  rsp_t res_q, out_q;

  logic              issue, advance, create_hit, match, find_hit;
  logic [DATA_W:0]   sum, diff;
  logic [DATA_W-1:0] up_v, dn_v, new_v;
  logic              s2_upd, s2_stamp_we;

  assign issue      = cmd_i.scan & ~issue_end_q;
  assign advance    = issue | cmd_i.create_step;
  assign create_hit = cmd_i.create_step & ~active_q[cnt_q];
  assign match      = s1_valid_q & active_q[s1_idx_q] & (rd_ident_q == target_id_q);
  assign find_hit   = cmd_i.find & match;

  always_comb begin
    sum   = {1'b0, s2_value_q} + {1'b0, s2_elapsed_q};
    diff  = {1'b0, s2_value_q} - {1'b0, s2_elapsed_q};
    up_v  = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    dn_v  = diff[DATA_W] ? '0 : diff[DATA_W-1:0];
    if (s2_dir_q) begin
      new_v = (up_v > s2_stop_q) ? s2_stop_q : up_v;
    end else begin
      new_v = (dn_v < s2_stop_q) ? s2_stop_q : dn_v;
    end
  end

  assign s2_stamp_we = s2_valid_q & s2_act_q;
  assign s2_upd      = s2_stamp_we & ~s2_halted_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q        <= now_time_i;
      start_q      <= start_value_i;
      stop_q       <= stop_value_i;
      count_up_q   <= count_up_i;
      pause_flag_q <= pause_flag_i;
      target_id_q  <= target_id_i;
      mode_q       <= mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      issue_end_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q       <= '0;
        issue_end_q <= 1'b0;
      end else if (advance) begin
        if (cnt_q == LAST_IDX) begin
          issue_end_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q & cmd_i.tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      finished_q <= '0;
      halted_q   <= '0;
      next_id_q  <= '0;
    end else begin
      if (create_hit) begin
        active_q[cnt_q]   <= 1'b1;
        finished_q[cnt_q] <= 1'b0;
        halted_q[cnt_q]   <= 1'b0;
        next_id_q         <= next_id_q + 1'b1;
      end
      if (find_hit) begin
        if (mode_q == MODE_DESTROY) begin
          active_q[s1_idx_q]   <= 1'b0;
          finished_q[s1_idx_q] <= 1'b0;
          halted_q[s1_idx_q]   <= 1'b0;
        end else if (mode_q == MODE_PAUSE) begin
          halted_q[s1_idx_q] <= pause_flag_q;
        end
      end
      if (s2_upd && (new_v == s2_stop_q)) begin
        finished_q[s2_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (create_hit) begin
      dir_mem[cnt_q]   <= count_up_q;
      stop_mem[cnt_q]  <= stop_q;
      ident_mem[cnt_q] <= next_id_q;
    end
    rd_dir_q   <= dir_mem[cnt_q];
    rd_stop_q  <= stop_mem[cnt_q];
    rd_ident_q <= ident_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (create_hit) begin
      value_mem[cnt_q] <= start_q;
    end else if (s2_upd) begin
      value_mem[s2_idx_q] <= new_v;
    end
    rd_value_q <= value_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (create_hit) begin
      stamp_mem[cnt_q] <= now_q;
    end else if (s2_stamp_we) begin
      stamp_mem[s2_idx_q] <= now_q;
    end
    rd_stamp_q <= stamp_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q     <= cnt_q;
    s2_idx_q     <= s1_idx_q;
    s2_elapsed_q <= now_q - rd_stamp_q;
    s2_value_q   <= rd_value_q;
    s2_stop_q    <= rd_stop_q;
    s2_dir_q     <= rd_dir_q;
    s2_act_q     <= active_q[s1_idx_q] & ~finished_q[s1_idx_q];
    s2_halted_q  <= halted_q[s1_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= '0;
    end else if (create_hit) begin
      res_q.ok        <= 1'b1;
      res_q.result_id <= next_id_q;
    end else if (find_hit) begin
      res_q.ok <= 1'b1;
      if (mode_q == MODE_QUERY) begin
        res_q.value_now <= rd_value_q;
        res_q.is_done   <= finished_q[s1_idx_q];
        res_q.is_paused <= halted_q[s1_idx_q];
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign st_o.free     = ~active_q[cnt_q];
  assign st_o.cnt_last = (cnt_q == LAST_IDX);
  assign st_o.s1_end   = s1_valid_q & (s1_idx_q == LAST_IDX);
  assign st_o.match    = match;
  assign st_o.tick_end = s2_valid_q & (s2_idx_q == LAST_IDX);
  assign rsp_o         = out_q;

endmodule

>>> design/timer_pool_manager_top.sv
// Top level of the timer pool manager: joins the controller and the datapath to the
// request and response channels. Depends on tpm_pkg, tpm_if, tpm_ctrl and tpm_datapath.
`timescale 1ns / 1ps

// A bank of NUM_TIMERS timer slots that count up or down toward their own stop values.
// Each request yields exactly one response. Requests are handled one at a time by a scan
// over the slots, one slot per cycle through the slot memories: create stops at the first
// free slot, destroy, query and pause stop at the first matching id, and tick visits
// every slot, each slot passing a read, an elapsed-time stage and a write-back stage.
// Other modes answer without a scan. A new request is taken while the previous response
// still waits on the response channel.

module timer_pool_manager_top import tpm_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpm_req_if.sink   req_i,
  tpm_rsp_if.source rsp_o
);

  ctl_cmd_t   cmd;
  dp_status_t st;
  rsp_t       rsp;

  tpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_mode_i   (req_i.mode),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  tpm_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .mode_i        (req_i.mode),
    .now_time_i    (req_i.now_time),
    .count_up_i    (req_i.count_up),
    .start_value_i (req_i.start_value),
    .stop_value_i  (req_i.stop_value),
    .target_id_i   (req_i.target_id),
    .pause_flag_i  (req_i.pause_flag),
    .rsp_o         (rsp)
  );

  assign rsp_o.ok        = rsp.ok;
  assign rsp_o.result_id = rsp.result_id;
  assign rsp_o.value_now = rsp.value_now;
  assign rsp_o.is_done   = rsp.is_done;
  assign rsp_o.is_paused = rsp.is_paused;

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("Response register loaded while a response is still pending.");

  a_find_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.find && st.match) |=> !cmd.find)
    else $error("Id search continued after a matching slot was found.");

  a_tick_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.tick_end |-> cmd.tick)
    else $error("Tick write-back stage active outside a tick request.");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.create_step, cmd.find, cmd.tick, cmd.out_load, cmd.load}))
    else $error("More than one datapath operation commanded at once.");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the timer pool manager: a directed table, then random requests.
// Holds its own timer bank predictor; depends on tpm_pkg, tpm_if and timer_pool_manager_top.
`timescale 1ns / 1ps

module tb import tpm_pkg::*; ();

  localparam int unsigned N_SLOTS      = 32;
  localparam int unsigned N_RANDOM     = 400;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = N_SLOTS + 16;

  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] now_time;
    logic              count_up;
    logic [DATA_W-1:0] start_value;
    logic [DATA_W-1:0] stop_value;
    logic [ID_W-1:0]   target_id;
    logic              pause_flag;
  } timer_req_t;

  typedef struct {
    timer_req_t req;
    bit         typed;
    rsp_t       rsp;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tpm_req_if req_if ();
  tpm_rsp_if rsp_if ();

  timer_pool_manager_top #(
    .NUM_TIMERS(N_SLOTS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predicted timer bank.
  bit                slot_used      [N_SLOTS];
  bit                slot_counts_up [N_SLOTS];
  logic [DATA_W-1:0] slot_limit     [N_SLOTS];
  logic [DATA_W-1:0] slot_count     [N_SLOTS];
  logic [DATA_W-1:0] slot_stamp     [N_SLOTS];
  bit                slot_done      [N_SLOTS];
  bit                slot_held      [N_SLOTS];
  logic [ID_W-1:0]   slot_id        [N_SLOTS];
  logic [ID_W-1:0]   id_counter = '0;

  rsp_t              expected_rsp_q [$];
  stim_row_t         stim_table     [$];
  logic [DATA_W-1:0] game_now = 32'h100;
  bit                steady_flow = 1'b0;
  int unsigned       err_cnt = 0;
  int unsigned       idle_cycles = 0;

  function automatic int find_timer(logic [ID_W-1:0] id);
    for (int i = 0; i < N_SLOTS; i++) begin
      if (slot_used[i] && slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void advance_timer(int i, logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] v;
    if (!slot_used[i] || slot_done[i]) return;
    elapsed = now - slot_stamp[i];
    slot_stamp[i] = now;
    if (slot_held[i]) return;
    v = slot_count[i];
    if (slot_counts_up[i]) begin
      v = (elapsed > ~v) ? '1 : v + elapsed;
      if (v > slot_limit[i]) v = slot_limit[i];
    end else begin
      v = (elapsed > v) ? '0 : v - elapsed;
      if (v < slot_limit[i]) v = slot_limit[i];
    end
    slot_count[i] = v;
    if (v == slot_limit[i]) slot_done[i] = 1'b1;
  endfunction

  function automatic rsp_t apply_timer_req(timer_req_t r);
    rsp_t rsp;
    int   i;
    rsp = '0;
    case (r.mode)
      MODE_CREATE: begin
        i = 0;
        while (i < N_SLOTS && slot_used[i]) i++;
        if (i < N_SLOTS) begin
          slot_id[i]        = id_counter;
          id_counter        = id_counter + 1'b1;
          slot_counts_up[i] = r.count_up;
          slot_count[i]     = r.start_value;
          slot_limit[i]     = r.stop_value;
          slot_held[i]      = 1'b0;
          slot_done[i]      = 1'b0;
          slot_used[i]      = 1'b1;
          slot_stamp[i]     = r.now_time;
          rsp.ok            = 1'b1;
          rsp.result_id     = slot_id[i];
        end
      end
      MODE_DESTROY: begin
        i = find_timer(r.target_id);
        if (i >= 0) begin
          slot_used[i] = 1'b0;
          slot_done[i] = 1'b0;
          slot_held[i] = 1'b0;
          rsp.ok       = 1'b1;
        end
      end
      MODE_TICK: begin
        for (int k = 0; k < N_SLOTS; k++) advance_timer(k, r.now_time);
      end
      MODE_QUERY: begin
        i = find_timer(r.target_id);
        if (i >= 0) begin
          rsp.ok        = 1'b1;
          rsp.value_now = slot_count[i];
          rsp.is_done   = slot_done[i];
          rsp.is_paused = slot_held[i];
        end
      end
      MODE_PAUSE: begin
        i = find_timer(r.target_id);
        if (i >= 0) begin
          slot_held[i] = r.pause_flag;
          rsp.ok       = 1'b1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic timer_req_t mk_req(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] now,
                                        logic up, logic [DATA_W-1:0] start,
                                        logic [DATA_W-1:0] stop, logic [ID_W-1:0] id,
                                        logic pflag);
    timer_req_t r;
    r.mode        = mode;
    r.now_time    = now;
    r.count_up    = up;
    r.start_value = start;
    r.stop_value  = stop;
    r.target_id   = id;
    r.pause_flag  = pflag;
    return r;
  endfunction

  function automatic void add_row(timer_req_t r, bit typed, logic ok, logic [ID_W-1:0] rid);
    stim_row_t row;
    row.req           = r;
    row.typed         = typed;
    row.rsp           = '0;
    row.rsp.ok        = ok;
    row.rsp.result_id = rid;
    stim_table.push_back(row);
  endfunction

  function automatic timer_req_t random_timer_req(int create_pct, int destroy_pct);
    timer_req_t        r;
    logic [ID_W-1:0]   live [$];
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] span;
    int                roll;
    foreach (slot_used[i]) begin
      if (slot_used[i]) live.push_back(slot_id[i]);
    end
    r.now_time    = $urandom;
    r.count_up    = 1'($urandom_range(0, 1));
    r.start_value = $urandom;
    r.stop_value  = $urandom;
    r.target_id   = ID_W'($urandom);
    r.pause_flag  = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < create_pct) begin
      r.mode = MODE_CREATE;
    end else if (roll < create_pct + destroy_pct) begin
      r.mode = MODE_DESTROY;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) r.mode = MODE_TICK;
      else if (roll < 75) r.mode = MODE_QUERY;
      else if (roll < 97) r.mode = MODE_PAUSE;
      else r.mode = MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    end
    if (r.mode == MODE_CREATE || r.mode == MODE_TICK) begin
      if ($urandom_range(0, 19) == 0) game_now = $urandom;
      else game_now = game_now + $urandom_range(0, 40);
      r.now_time = game_now;
    end
    if (r.mode == MODE_CREATE) begin
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        r.stop_value = r.start_value;
      end else if (roll > 2) begin
        base = $urandom_range(0, 300);
        span = $urandom_range(0, 600);
        r.start_value = r.count_up ? base : base + span;
        r.stop_value  = r.count_up ? base + span : base;
      end
    end
    roll = $urandom_range(0, 9);
    if (live.size() > 0 && roll < 8) r.target_id = live[$urandom_range(0, live.size() - 1)];
    else if (roll < 9) r.target_id = ID_W'($urandom_range(0, id_counter + 2));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic send_timer_req(timer_req_t r, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t predicted;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.now_time    <= r.now_time;
    req_if.count_up    <= r.count_up;
    req_if.start_value <= r.start_value;
    req_if.stop_value  <= r.stop_value;
    req_if.target_id   <= r.target_id;
    req_if.pause_flag  <= r.pause_flag;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = apply_timer_req(r);
    expected_rsp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic check_timer_rsp();
    rsp_t got;
    rsp_t want;
    got.ok        = rsp_if.ok;
    got.result_id = rsp_if.result_id;
    got.value_now = rsp_if.value_now;
    got.is_done   = rsp_if.is_done;
    got.is_paused = rsp_if.is_paused;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch("unrequested response ok", DATA_W'(got.ok), 'x);
      return;
    end
    want = expected_rsp_q.pop_front();
    if (got.ok !== want.ok) begin
      report_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
    end
    if (got.result_id !== want.result_id) begin
      report_mismatch("result_id", DATA_W'(got.result_id), DATA_W'(want.result_id));
    end
    if (got.value_now !== want.value_now) begin
      report_mismatch("value_now", got.value_now, want.value_now);
    end
    if (got.is_done !== want.is_done) begin
      report_mismatch("is_done", DATA_W'(got.is_done), DATA_W'(want.is_done));
    end
    if (got.is_paused !== want.is_paused) begin
      report_mismatch("is_paused", DATA_W'(got.is_paused), DATA_W'(want.is_paused));
    end
  endtask

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      check_timer_rsp();
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int create_pct;
    int destroy_pct;
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.mode        <= MODE_CREATE;
    req_if.now_time    <= '0;
    req_if.count_up    <= 1'b0;
    req_if.start_value <= '0;
    req_if.stop_value  <= '0;
    req_if.target_id   <= '0;
    req_if.pause_flag  <= 1'b0;

    // An empty bank answers every lookup with not found.
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, '0, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_DESTROY, '0, 0, '0, '0, '0, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_PAUSE,   '0, 0, '0, '0, '0, 1), TYPED, 0, 0);
    add_row(mk_req(MODE_TICK,    '0, 0, '0, '0, '0, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_RSVD5,   '1, 1, '1, '1, '1, 1), TYPED, 0, 0);
    add_row(mk_req(MODE_RSVD6,   '1, 1, '1, '1, '1, 1), TYPED, 0, 0);
    add_row(mk_req(MODE_RSVD7,   '1, 1, '1, '1, '1, 1), TYPED, 0, 0);
    add_row(mk_req(MODE_CREATE,  '0, 1, '0, '1, '0, 0), TYPED, 1, 0);
    add_row(mk_req(MODE_CREATE,  '0, 0, '1, '0, '0, 0), TYPED, 1, 1);
    add_row(mk_req(MODE_CREATE,  '0, 1, 32'd5, 32'd5, '0, 0), TYPED, 1, 2);
    add_row(mk_req(MODE_CREATE,  '0, 0, 32'd10, 32'd20, '0, 0), TYPED, 1, 3);
    add_row(mk_req(MODE_CREATE,  32'hFFFF_FFF0, 1, 32'hFFFF_FFF0, '1, '0, 0), TYPED, 1, 4);
    add_row(mk_req(MODE_CREATE,  '0, 1, '0, 32'd1000, '0, 0), TYPED, 1, 5);
    add_row(mk_req(MODE_PAUSE,   '0, 0, '0, '0, 31'd5, 1), TYPED, 1, 0);
    add_row(mk_req(MODE_TICK,    32'h10, 0, '0, '0, '0, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd4, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd3, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd5, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_PAUSE,   '0, 0, '0, '0, 31'd5, 0), TYPED, 1, 0);
    add_row(mk_req(MODE_TICK,    32'hF, 0, '0, '0, '0, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd0, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd1, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd5, 0), PREDICTED, 0, 0);
    add_row(mk_req(MODE_DESTROY, '0, 0, '0, '0, 31'd2, 0), TYPED, 1, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, 31'd2, 0), TYPED, 0, 0);
    add_row(mk_req(MODE_QUERY,   '0, 0, '0, '0, '1, 0), TYPED, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[k]) begin
      send_timer_req(stim_table[k].req, stim_table[k].typed, stim_table[k].rsp);
    end

    // Phases alternate between filling the bank, mixed traffic and draining it.
    for (int n = 0; n < N_RANDOM; n++) begin
      steady_flow = (n % 100) >= 70;
      case ((n / 50) % 4)
        0:       begin create_pct = 55; destroy_pct = 5;  end
        2:       begin create_pct = 10; destroy_pct = 45; end
        default: begin create_pct = 25; destroy_pct = 15; end
      endcase
      send_timer_req(random_timer_req(create_pct, destroy_pct), PREDICTED, '0);
    end
    req_if.valid <= 1'b0;
    steady_flow = 1'b0;

    wait (expected_rsp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tpm_pkg.sv
design/tpm_if.sv
design/tpm_ctrl.sv
design/tpm_datapath.sv
design/timer_pool_manager_top.sv
tb/tb.sv
